[rtl/core/nested_comment_stripper_unit_assert.svh]
// assertion macros shared by the comment stripper rtl
// expects aclk and aresetn in the scope of every use
`ifndef NESTED_COMMENT_STRIPPER_UNIT_ASSERT_SVH
`define NESTED_COMMENT_STRIPPER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NCS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed in comment stripper");

// next-cycle implication, checked outside reset
`define NCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed in comment stripper");

`endif

[rtl/core/ncs_pkg.sv]
// shared types and constants of the nested comment stripper
// no dependencies
`default_nettype none

package ncs_pkg;

    localparam int DEPTH_BITS = 8;

    // result queue between the scan logic and the output port
    localparam int OUT_QDEPTH   = 4;
    localparam int OUT_PTR_BITS = $clog2(OUT_QDEPTH);
    localparam int OUT_CNT_BITS = $clog2(OUT_QDEPTH + 1);

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_DOUBLE = 2'd1,
        Q_SINGLE = 2'd2
    } quote_t;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth;
        quote_t                quote;
        logic                  esc;
        logic                  held_valid;
        logic [7:0]            held_char;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        depth:      '0,
        quote:      Q_NONE,
        esc:        1'b0,
        held_valid: 1'b0,
        held_char:  8'h00
    };

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } result_t;

    // up to two results per request, r0 first; valid1 only with valid0
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t r0;
        result_t r1;
    } result_pair_t;

endpackage

`default_nettype wire

[rtl/core/nested_comment_stripper_unit.sv]
// top level of the nested block comment stripper
// depends on ncs_pkg, ncs_step, ncs_out_queue and the assertion macro header
`default_nettype none
`include "nested_comment_stripper_unit_assert.svh"

// channel   dir  tdata            tuser          tlast
// s_        in   in_byte [7:0]    -              end_of_text
// m_        out  out_byte [7:0]   byte_present   final_result
//
// one request per cycle sustained while m_ does not stall; a result
// leaves through the input register, then the result queue
// the end-of-text request may give two results, so the queue takes a
// request only while two entries are free
// aresetn is synchronous, active low; it clears the scan state and queue
// a stall on m_ backs up through the queue into the input register

module nested_comment_stripper_unit
    import ncs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // byte_present
    output logic            m_tlast    // final_result
);

    // input register
    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;

    // scan state: depth, quote mode, escape, held look-ahead byte
    scan_state_t  state_reg;
    scan_state_t  state_next;

    result_pair_t step_out;
    result_pair_t push;
    result_t      q_item;
    logic         room;
    logic         fire;

    // the registered request is processed when the queue can take a pair
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= SCAN_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    // payload only, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ncs_step u_step (
        .cur_state (state_reg),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .nxt_state (state_next),
        .results   (step_out)
    );

    // gate the result valids with the processing strobe
    always_comb begin
        push        = step_out;
        push.valid0 = step_out.valid0 && fire;
        push.valid1 = step_out.valid1 && fire;
    end

    ncs_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (q_item)
    );

    assign m_tdata = q_item.data;
    assign m_tuser = q_item.present;
    assign m_tlast = q_item.last;

    // end of text returns the scan to its reset state
    `NCS_ASSERT_NEXT(a_last_clears_state, fire && in_last_reg, state_reg == SCAN_RESET)
    // end of text always yields a result, and the last pushed one is marked
    `NCS_ASSERT_IMPL(a_last_marks_final, fire && in_last_reg, push.valid0 && (push.valid1 ? push.r1.last : push.r0.last))
    // a held request without queue room stalls the input side
    `NCS_ASSERT_IMPL(a_full_stalls_input, in_valid_reg && !room, !s_tready)

endmodule

`default_nettype wire

[rtl/core/ncs_step.sv]
// per-byte scan logic of the comment stripper: next state and results
// depends on ncs_pkg
`default_nettype none

module ncs_step
    import ncs_pkg::*;
(
    input  wire scan_state_t  cur_state,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    output scan_state_t       nxt_state,
    output result_pair_t      results
);

    typedef struct packed {
        scan_state_t st;
        logic        pair;
        logic        keep;
    } judge_t;

    function automatic judge_t judge(scan_state_t st, logic [7:0] c,
                                     logic has_next, logic [7:0] nx);
        judge_t j;
        logic   open;
        j      = '{st: st, pair: 1'b0, keep: 1'b0};
        open   = (st.depth == '0);
        if (st.esc) begin
            j.st.esc = 1'b0;
            j.keep   = open;
        end else if (st.quote != Q_NONE) begin
            if (c == CH_BSLASH) begin
                j.st.esc = 1'b1;
            end else if ((st.quote == Q_DOUBLE && c == CH_DQUOTE) ||
                         (st.quote == Q_SINGLE && c == CH_SQUOTE)) begin
                j.st.quote = Q_NONE;
            end
            j.keep = open;
        end else if (c == CH_DQUOTE) begin
            j.st.quote = Q_DOUBLE;
            j.keep     = open;
        end else if (c == CH_SQUOTE) begin
            j.st.quote = Q_SINGLE;
            j.keep     = open;
        end else if (has_next && c == CH_SLASH && nx == CH_STAR) begin
            // saturate at the top of the depth range
            if (st.depth != '1) begin
                j.st.depth = st.depth + 1'b1;
            end
            j.pair = 1'b1;
        end else if (has_next && !open && c == CH_STAR && nx == CH_SLASH) begin
            j.st.depth = st.depth - 1'b1;
            j.pair     = 1'b1;
        end else begin
            j.keep = open;
        end
        return j;
    endfunction

    judge_t      j1;
    judge_t      j2;
    scan_state_t s1;
    logic        keep_a;
    logic        keep_b;

    always_comb begin
        j1     = judge(cur_state, cur_state.held_char, 1'b1, in_byte);
        s1     = cur_state;
        keep_a = 1'b0;
        if (cur_state.held_valid) begin
            s1 = j1.st;
            if (j1.pair) begin
                s1.held_valid = 1'b0;
                s1.held_char  = 8'h00;
            end else begin
                keep_a       = j1.keep;
                s1.held_char = in_byte;
            end
        end else begin
            s1.held_valid = 1'b1;
            s1.held_char  = in_byte;
        end

        // end of text: flush the held byte with no successor
        j2     = judge(s1, s1.held_char, 1'b0, 8'h00);
        keep_b = in_last && s1.held_valid && j2.keep;

        nxt_state = in_last ? SCAN_RESET : s1;
    end

    always_comb begin
        results.valid0     = keep_a || keep_b || in_last;
        results.valid1     = keep_a && keep_b;
        results.r0.data    = keep_a ? cur_state.held_char :
                             (keep_b ? s1.held_char : 8'h00);
        results.r0.present = keep_a || keep_b;
        results.r0.last    = in_last && !(keep_a && keep_b);
        results.r1.data    = s1.held_char;
        results.r1.present = 1'b1;
        results.r1.last    = 1'b1;
    end

endmodule

`default_nettype wire

[rtl/core/ncs_out_queue.sv]
// small result queue: up to two pushes per cycle, one pop per cycle
// depends on ncs_pkg and the assertion macro header
`default_nettype none
`include "nested_comment_stripper_unit_assert.svh"

module ncs_out_queue
    import ncs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire result_pair_t push,
    output logic              room,
    output logic              out_valid,
    input  wire logic         out_ready,
    output result_t           out_item
);

    result_t                  entry_reg [OUT_QDEPTH];
    logic [OUT_PTR_BITS-1:0]  head_reg;
    logic [OUT_PTR_BITS-1:0]  head_next;
    logic [OUT_PTR_BITS-1:0]  tail_reg;
    logic [OUT_PTR_BITS-1:0]  tail_next;
    logic [OUT_PTR_BITS-1:0]  tail_p1;
    logic [OUT_CNT_BITS-1:0]  count_reg;
    logic [OUT_CNT_BITS-1:0]  count_next;
    logic [1:0]               push_n;
    logic                     pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[head_reg];
    assign pop       = out_valid && out_ready;
    // room for a full pair of results
    assign room      = (count_reg <= OUT_CNT_BITS'(OUT_QDEPTH - 2));
    assign push_n    = {1'b0, push.valid0} + {1'b0, push.valid1};
    assign tail_p1   = tail_reg + 1'b1;

    always_comb begin
        tail_next  = tail_reg + OUT_PTR_BITS'(push_n);
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        count_next = count_reg + OUT_CNT_BITS'(push_n) - OUT_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            entry_reg[tail_reg] <= push.r0;
        end
        if (push.valid1) begin
            entry_reg[tail_p1] <= push.r1;
        end
    end

    `NCS_ASSERT_IMPL(a_count_range, 1'b1, count_reg <= OUT_CNT_BITS'(OUT_QDEPTH))
    `NCS_ASSERT_IMPL(a_push_has_room, push.valid0 || push.valid1, room)
    `NCS_ASSERT_IMPL(a_pair_in_order, push.valid1, push.valid0)

endmodule

`default_nettype wire
